@@ rtl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the port statistics counter block.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

   // Sizes and reset values.
   localparam int          DEFAULT_NUM_PORTS = 32;
   localparam int          NUM_STATS         = 11;
   localparam int          CNT_W             = 64;
   localparam int          PORT_W            = 5;
   localparam int          SIZE_W            = 16;
   localparam int          MAC_W             = 48;
   localparam int          ACTIVE_W          = 6;
   localparam int          SEL_W             = 4;
   localparam logic [15:0] DEFAULT_MTU       = 16'd1500;
   localparam logic [5:0]  DEFAULT_ACTIVE    = 6'd24;
   localparam int          MAC_GROUP_BIT     = 40;

   // Counter slots within one port's row.
   localparam logic [3:0] STAT_RX_PKTS  = 4'd0;
   localparam logic [3:0] STAT_TX_PKTS  = 4'd5;
   localparam logic [3:0] STAT_TX_DROPS = 4'd10;
   localparam logic [3:0] STAT_COUNT    = 4'd11;

   // Operation codes.
   typedef enum logic [2:0] {
      OP_RX     = 3'd0,
      OP_TX     = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_CONFIG = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_BAD_PORT = 2'd1,
      STS_DOWN     = 2'd2,
      STS_MTU      = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_state_type;

   // One port's counters, held as a single memory row.
   typedef logic [NUM_STATS-1:0][CNT_W-1:0] stat_row_type;

   // Write-side control towards the counter bank.
   typedef struct packed {
      logic wr;
      logic clr;
   } bank_cmd_type;

endpackage

`default_nettype wire

@@ rtl/psc_if.sv @@
// ----------------------------------------------------------------------------
// psc_if
// Valid/ready channels of the port statistics counter block.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one operation per request.
interface psc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [4:0]  port;
   logic [15:0] packet_size;
   logic [47:0] dst_mac;
   logic        admin_up;
   logic [15:0] mtu_value;
   logic        link_ok;
   logic [3:0]  counter_select;

   modport source (output valid, operation, port, packet_size, dst_mac, admin_up,
                   mtu_value, link_ok, counter_select, input ready);
   modport sink   (input valid, operation, port, packet_size, dst_mac, admin_up,
                   mtu_value, link_ok, counter_select, output ready);
endinterface

// Result channel: one result per request.
interface psc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        dropped;
   logic [63:0] counter_value;
   logic        port_up;

   modport source (output valid, status, dropped, counter_value, port_up, input ready);
   modport sink   (input valid, status, dropped, counter_value, port_up, output ready);
endinterface

// Register write channel for active_ports.
interface psc_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/psc_counter_bank.sv @@
// ----------------------------------------------------------------------------
// psc_counter_bank
// Counter memory, one row of eleven 64-bit counters per port, with a
// registered read and a per-row valid flag that makes a row read as zero
// after reset or after a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_counter_bank
   import psc_pkg::*;
#(
   parameter int  NUM_PORTS = DEFAULT_NUM_PORTS,
   localparam int IDX_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output stat_row_type      rd_row,
   input  wire bank_cmd_type cmd,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire stat_row_type wr_row
);

   stat_row_type           stat_mem_ff [NUM_PORTS];
   stat_row_type           rd_data_ff;
   logic                   rd_valid_ff;
   logic [NUM_PORTS-1:0]   row_valid_ff;

   // Row valid flags: cleared together at reset, set by a write back,
   // dropped by a clear request.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.wr) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end else if (cmd.clr) begin
         row_valid_ff[wr_addr] <= 1'b0;
      end
   end

   // Memory array with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         stat_mem_ff[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= stat_mem_ff[rd_addr];
      end
   end

   // The valid flag is sampled alongside the read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/port_statistics_counters_top.sv @@
// A result is registered in the execute state once the result register is free;
// a new request is taken only after the previous one has executed, set by the
// read and write back of the addressed port's row in the counter memory.
// Reset: counters read as zero at once through per-row valid flags, so no
// clearing pass is needed; links are down, every MTU is 1500 and
// active_ports is 24.
// ----------------------------------------------------------------------------
// port_statistics_counters_top
// Per-port switch statistics: receive and transmit counting, clear,
// port configuration and counter read.
// ----------------------------------------------------------------------------
`default_nettype none

module port_statistics_counters_top
   import psc_pkg::*;
#(
   parameter int NUM_PORTS = DEFAULT_NUM_PORTS
) (
   input wire logic clock,
   input wire logic reset,
   psc_req_if.sink   req_bus,
   psc_rsp_if.source rsp_bus,
   psc_csr_if.sink   csr_bus
);

   localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   fsm_state_type         state_ff, state_in;
   logic [ACTIVE_W-1:0]   active_ports_ff;

   // Captured request.
   logic [2:0]            op_ff;
   logic [PORT_W-1:0]     port_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [MAC_W-1:0]      mac_ff;
   logic                  adm_ff;
   logic [SIZE_W-1:0]     mtu_val_ff;
   logic                  lok_ff;
   logic [SEL_W-1:0]      sel_ff;

   // Per-port configuration state.
   logic [SIZE_W-1:0]     mtu_ff [NUM_PORTS];
   logic [NUM_PORTS-1:0]  link_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_dropped_ff;
   logic [CNT_W-1:0]      rsp_value_ff;
   logic                  rsp_up_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  exec_fire;
   logic [IDX_W+PORT_W-1:0] req_port_wide;
   logic [IDX_W+PORT_W-1:0] cur_port_wide;
   logic [IDX_W-1:0]      rd_idx;
   logic [IDX_W-1:0]      cur_idx;

   stat_row_type          row;
   stat_row_type          new_row;
   bank_cmd_type          cmd;
   logic                  do_write;
   logic                  do_clear;
   logic                  do_config;
   logic                  port_ok;
   logic                  cur_link;
   logic [SIZE_W-1:0]     cur_mtu;
   logic [1:0]            mac_cls;
   logic [3:0]            first_i;
   logic [3:0]            bytes_i;
   logic [3:0]            cls_i;
   logic [1:0]            res_status;
   logic                  res_dropped;
   logic [CNT_W-1:0]      res_value;
   logic                  res_up;

   // Port numbers widened or narrowed to the row index width.
   assign req_port_wide = {{IDX_W{1'b0}}, req_bus.port};
   assign cur_port_wide = {{IDX_W{1'b0}}, port_ff};
   assign rd_idx        = req_port_wide[IDX_W-1:0];
   assign cur_idx       = cur_port_wide[IDX_W-1:0];

   // Handshake conditions.
   assign req_accept = req_bus.valid && req_bus.ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Sequencer outputs; no request is taken while reset is held.
   always_comb begin
      req_bus.ready = 1'b0;
      exec_fire     = 1'b0;
      case (state_ff)
         FSM_IDLE: req_bus.ready = !reset;
         FSM_EXEC: exec_fire     = out_free;
         default: begin
            req_bus.ready = 1'b0;
            exec_fire     = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration register; the user must write it only while the block is idle, the block does not enforce it.
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ports_ff <= DEFAULT_ACTIVE;
      end else if (csr_bus.valid) begin
         active_ports_ff <= csr_bus.data;
      end
   end

   // Capture the request at acceptance.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_bus.operation;
         port_ff    <= req_bus.port;
         size_ff    <= req_bus.packet_size;
         mac_ff     <= req_bus.dst_mac;
         adm_ff     <= req_bus.admin_up;
         mtu_val_ff <= req_bus.mtu_value;
         lok_ff     <= req_bus.link_ok;
         sel_ff     <= req_bus.counter_select;
      end
   end

   // Counter memory.
   psc_counter_bank #(
      .NUM_PORTS (NUM_PORTS)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (rd_idx),
      .rd_row  (row),
      .cmd     (cmd),
      .wr_addr (cur_idx),
      .wr_row  (new_row)
   );

   // Port validity and the port's current configuration.
   assign port_ok  = ({1'b0, port_ff} < active_ports_ff) && (32'(port_ff) < NUM_PORTS);
   assign cur_link = port_ok && link_ff[cur_idx];
   assign cur_mtu  = mtu_ff[cur_idx];

   // Destination class: unicast, multicast or broadcast.
   always_comb begin
      if (!mac_ff[MAC_GROUP_BIT]) begin
         mac_cls = 2'd0;
      end else if (mac_ff == {MAC_W{1'b1}}) begin
         mac_cls = 2'd2;
      end else begin
         mac_cls = 2'd1;
      end
   end

   // Operation: update of the port's row and the result fields.
   always_comb begin
      new_row     = row;
      do_write    = 1'b0;
      do_clear    = 1'b0;
      do_config   = 1'b0;
      res_status  = STS_OK;
      res_dropped = 1'b0;
      res_value   = '0;
      res_up      = cur_link;
      first_i     = (op_ff == OP_TX) ? STAT_TX_PKTS : STAT_RX_PKTS;
      bytes_i     = first_i + 4'd1;
      cls_i       = first_i + 4'd2 + {2'b00, mac_cls};

      if (!port_ok) begin
         res_up = 1'b0;
         if (op_ff <= OP_READ) begin
            res_status = STS_BAD_PORT;
         end
         if (op_ff == OP_TX) begin
            res_dropped = 1'b1;
         end
      end else begin
         case (op_type'(op_ff))
            OP_RX, OP_TX: begin
               if (!cur_link) begin
                  res_status  = STS_DOWN;
                  res_dropped = (op_ff == OP_TX);
               end else if ((op_ff == OP_TX) && (size_ff > cur_mtu)) begin
                  res_status             = STS_MTU;
                  res_dropped            = 1'b1;
                  do_write               = 1'b1;
                  new_row[STAT_TX_DROPS] = row[STAT_TX_DROPS] + 64'd1;
               end else begin
                  do_write         = 1'b1;
                  new_row[first_i] = row[first_i] + 64'd1;
                  new_row[bytes_i] = row[bytes_i] + CNT_W'(size_ff);
                  new_row[cls_i]   = row[cls_i] + 64'd1;
               end
            end
            OP_CLEAR: begin
               do_clear = 1'b1;
            end
            OP_CONFIG: begin
               do_config = 1'b1;
               res_up    = adm_ff && lok_ff;
            end
            OP_READ: begin
               if (sel_ff < STAT_COUNT) begin
                  res_value = row[sel_ff];
               end
            end
            default: begin
               res_status = STS_OK;
            end
         endcase
      end
   end

   assign cmd.wr  = exec_fire && do_write;
   assign cmd.clr = exec_fire && do_clear;

   // Per-port MTU and link state; the admin flag only matters for the
   // link outcome and is folded into it here.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
         for (int i = 0; i < NUM_PORTS; i++) begin
            mtu_ff[i] <= DEFAULT_MTU;
         end
      end else if (exec_fire && do_config) begin
         link_ff[cur_idx] <= adm_ff && lok_ff;
         mtu_ff[cur_idx]  <= mtu_val_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff  <= res_status;
         rsp_dropped_ff <= res_dropped;
         rsp_value_ff   <= res_value;
         rsp_up_ff      <= res_up;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.dropped       = rsp_dropped_ff;
   assign rsp_bus.counter_value = rsp_value_ff;
   assign rsp_bus.port_up       = rsp_up_ff;

endmodule

`default_nettype wire

@@ sim/port_statistics_counters_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_statistics_counters_top_tb
// Self-checking bench for the port statistics block. A scoreboard keeps its
// own copy of the per-port counters, MTUs and link states. It predicts the
// result of every accepted request and compares the block's results with
// those predictions in order. A short directed run covers the corner cases.
// Random phases then follow, each with its own active_ports setting, while
// both sides of the block idle and stall at random in most phases.
// ----------------------------------------------------------------------------

module port_statistics_counters_top_tb;
   import psc_pkg::*;

   // Operation codes that the block does not define.
   localparam logic [2:0] OP_SPARE_LOW  = 3'd5;
   localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

   // Offsets of the MAC class counters after the packet and byte counters.
   typedef enum int {
      MAC_UNICAST   = 0,
      MAC_MULTICAST = 1,
      MAC_BROADCAST = 2
   } mac_class_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic [PORT_W-1:0] port;
      logic [SIZE_W-1:0] packet_size;
      logic [MAC_W-1:0]  dst_mac;
      logic              admin_up;
      logic [15:0]       mtu_value;
      logic              link_ok;
      logic [SEL_W-1:0]  counter_select;
   } stats_request_type;

   typedef struct packed {
      status_type       status;
      logic             dropped;
      logic [CNT_W-1:0] counter_value;
      logic             port_up;
   } stats_result_type;

   // Scoreboard: tracks the port state and queues the predicted results.
   class port_stats_scoreboard_type;
      logic [CNT_W-1:0]  counters [DEFAULT_NUM_PORTS][NUM_STATS];
      logic [SIZE_W-1:0] mtu [DEFAULT_NUM_PORTS];
      logic              link_up [DEFAULT_NUM_PORTS];
      logic [ACTIVE_W-1:0] active_ports;
      stats_result_type  pending_outcomes[$];
      int                failures;

      function new();
         foreach (counters[p, s]) counters[p][s] = '0;
         foreach (mtu[p]) begin
            mtu[p]     = DEFAULT_MTU;
            link_up[p] = 1'b0;
         end
         active_ports = DEFAULT_ACTIVE;
         failures     = 0;
      endfunction

      // Works out the result of one accepted request and updates the state.
      function void note_request(stats_request_type r);
         stats_result_type res;
         mac_class_type    cls;
         int               first;
         int               p;
         res        = '0;
         res.status = STS_OK;
         p          = r.port;
         if (!(r.port < active_ports && r.port < DEFAULT_NUM_PORTS)) begin
            if (r.operation <= OP_READ) res.status = STS_BAD_PORT;
            if (r.operation == OP_TX) res.dropped = 1'b1;
         end else begin
            if (!r.dst_mac[MAC_GROUP_BIT]) cls = MAC_UNICAST;
            else if (&r.dst_mac) cls = MAC_BROADCAST;
            else cls = MAC_MULTICAST;
            first = (r.operation == OP_RX) ? STAT_RX_PKTS : STAT_TX_PKTS;
            case (r.operation)
               OP_RX, OP_TX: begin
                  if (!link_up[p]) begin
                     res.status  = STS_DOWN;
                     res.dropped = (r.operation == OP_TX);
                  end else if (r.operation == OP_TX && r.packet_size > mtu[p]) begin
                     counters[p][STAT_TX_DROPS] += 1;
                     res.status  = STS_MTU;
                     res.dropped = 1'b1;
                  end else begin
                     // Packets, then bytes, then the three MAC classes.
                     counters[p][first]                 += 1;
                     counters[p][first + 1]             += r.packet_size;
                     counters[p][first + 2 + int'(cls)] += 1;
                  end
               end
               OP_CLEAR: begin
                  for (int s = 0; s < NUM_STATS; s++) counters[p][s] = '0;
               end
               OP_CONFIG: begin
                  mtu[p]     = r.mtu_value;
                  link_up[p] = r.admin_up & r.link_ok;
               end
               OP_READ: begin
                  if (r.counter_select < STAT_COUNT)
                     res.counter_value = counters[p][r.counter_select];
               end
               default: ;
            endcase
            res.port_up = link_up[p];
         end
         pending_outcomes.push_back(res);
      endfunction

      function void compare_field(string field, logic [CNT_W-1:0] want,
                                  logic [CNT_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            failures++;
         end
      endfunction

      // Compares one accepted result with the oldest prediction.
      function void check_result(stats_result_type got);
         stats_result_type want;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual 0x%0h",
                     $time, got);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("dropped", want.dropped, got.dropped);
            compare_field("counter_value", want.counter_value, got.counter_value);
            compare_field("port_up", want.port_up, got.port_up);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   psc_req_if req_bus ();
   psc_rsp_if rsp_bus ();
   psc_csr_if csr_bus ();

   port_stats_scoreboard_type tracker = new();

   // Shared controls between the stimulus and the result sink.
   bit sender_calm;
   bit sink_calm;
   int hold_results_cycles;

   port_statistics_counters_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Random request, weighted towards sequences that get past link down.
   function automatic stats_request_type random_request();
      stats_request_type r;
      int                pick;
      int                span;
      logic [63:0]       raw;
      pick = $urandom_range(0, 99);
      if (pick < 30) r.operation = OP_RX;
      else if (pick < 60) r.operation = OP_TX;
      else if (pick < 72) r.operation = OP_CONFIG;
      else if (pick < 90) r.operation = OP_READ;
      else if (pick < 95) r.operation = OP_CLEAR;
      else r.operation = 3'($urandom_range(OP_SPARE_LOW, OP_SPARE_HIGH));

      span = (tracker.active_ports > DEFAULT_NUM_PORTS) ? DEFAULT_NUM_PORTS
                                                        : tracker.active_ports;
      if (span > 0 && $urandom_range(0, 99) < 85)
         r.port = PORT_W'($urandom_range(0, span - 1));
      else r.port = PORT_W'($urandom_range(0, DEFAULT_NUM_PORTS - 1));

      pick = $urandom_range(0, 99);
      if (pick < 70) r.packet_size = SIZE_W'($urandom_range(0, 2000));
      else if (pick < 85) r.packet_size = SIZE_W'($urandom_range(1400, 1600));
      else r.packet_size = SIZE_W'($urandom_range(0, 16'hFFFF));

      raw       = {$urandom, $urandom};
      r.dst_mac = raw[MAC_W-1:0];
      pick      = $urandom_range(0, 99);
      if (pick < 40) r.dst_mac[MAC_GROUP_BIT] = 1'b0;
      else if (pick < 75) r.dst_mac[MAC_GROUP_BIT] = 1'b1;
      else if (pick < 85) r.dst_mac = '1;

      r.admin_up = ($urandom_range(0, 9) < 8);
      r.link_ok  = ($urandom_range(0, 9) < 8);
      pick       = $urandom_range(0, 99);
      if (pick < 60) r.mtu_value = 16'($urandom_range(1400, 1600));
      else if (pick < 80) r.mtu_value = 16'($urandom_range(0, 9000));
      else r.mtu_value = 16'($urandom_range(0, 16'hFFFF));

      if ($urandom_range(0, 9) < 9)
         r.counter_select = SEL_W'($urandom_range(0, NUM_STATS - 1));
      else r.counter_select = SEL_W'($urandom_range(NUM_STATS, 15));
      return r;
   endfunction

   // Offers one request after a random gap; valid stays high if the next
   // request follows without a gap.
   task automatic issue_request(input stats_request_type r);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.operation      <= r.operation;
      req_bus.port           <= r.port;
      req_bus.packet_size    <= r.packet_size;
      req_bus.dst_mac        <= r.dst_mac;
      req_bus.admin_up       <= r.admin_up;
      req_bus.mtu_value      <= r.mtu_value;
      req_bus.link_ok        <= r.link_ok;
      req_bus.counter_select <= r.counter_select;
      req_bus.valid          <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_request(r);
      @(negedge clock);
   endtask

   // Withdraws the request and waits until every predicted result is in.
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (tracker.pending_outcomes.size() != 0);
   endtask

   task automatic write_active_ports(input logic [ACTIVE_W-1:0] value);
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      tracker.active_ports = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Result sink: random stall before each result, plus one long hold-off.
   initial begin : result_sink
      int               stall;
      stats_result_type got;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = sink_calm ? 0 : $urandom_range(0, 13);
         if (hold_results_cycles > 0) begin
            stall               = hold_results_cycles;
            hold_results_cycles = 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.status        = status_type'(rsp_bus.status);
         got.dropped       = rsp_bus.dropped;
         got.counter_value = rsp_bus.counter_value;
         got.port_up       = rsp_bus.port_up;
         tracker.check_result(got);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int phase_active[6];
      req_bus.valid          <= 1'b0;
      req_bus.operation      <= '0;
      req_bus.port           <= '0;
      req_bus.packet_size    <= '0;
      req_bus.dst_mac        <= '0;
      req_bus.admin_up       <= 1'b0;
      req_bus.mtu_value      <= '0;
      req_bus.link_ok        <= 1'b0;
      req_bus.counter_select <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.data           <= '0;
      reset                  <= 1'b1;
      sender_calm            = 1'b0;
      sink_calm              = 1'b0;
      hold_results_cycles    = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corner cases with the reset port count.
      write_active_ports(DEFAULT_ACTIVE);
      // Links start down, and ports at or above active_ports are refused.
      issue_request('{OP_RX, 5'd0, 16'd64, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_TX, 5'd0, 16'd64, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_TX, 5'd24, 16'd64, 48'h0, 1'b1, 16'd0, 1'b1, 4'd0});
      issue_request('{OP_CLEAR, 5'd31, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      // The link needs both the admin enable and a good link outcome.
      issue_request('{OP_CONFIG, 5'd0, 16'd0, 48'h0, 1'b1, 16'd1500, 1'b0, 4'd0});
      issue_request('{OP_CONFIG, 5'd0, 16'd0, 48'h0, 1'b0, 16'd1500, 1'b1, 4'd0});
      issue_request('{OP_CONFIG, 5'd0, 16'd0, 48'h0, 1'b1, 16'hFFFF, 1'b1, 4'd0});
      // Frames of each MAC class on receive, several at the size extremes.
      issue_request('{OP_RX, 5'd0, 16'hFFFF, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_RX, 5'd0, 16'd0, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_RX, 5'd0, 16'd60, 48'h0100_5E00_0001, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_TX, 5'd0, 16'hFFFF, 48'hFFFF_FFFF_FFFE, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_TX, 5'd0, 16'd1, 48'hFEFF_FFFF_FFFF, 1'b0, 16'd0, 1'b0, 4'd0});
      // An MTU of zero passes only empty frames.
      issue_request('{OP_CONFIG, 5'd23, 16'd0, 48'h0, 1'b1, 16'd0, 1'b1, 4'd0});
      issue_request('{OP_TX, 5'd23, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_TX, 5'd23, 16'd1, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_READ, 5'd23, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd10});
      // Counter reads, including selects past the last counter.
      issue_request('{OP_READ, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_READ, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd4});
      issue_request('{OP_READ, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd6});
      issue_request('{OP_READ, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd11});
      issue_request('{OP_READ, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd15});
      // Undefined operations change nothing, on a valid and an invalid port.
      issue_request('{OP_SPARE_LOW, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_SPARE_HIGH, 5'd31, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_CLEAR, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd0});
      issue_request('{OP_READ, 5'd0, 16'd0, 48'h0, 1'b0, 16'd0, 1'b0, 4'd1});
      wait_until_drained();

      // Random phases, each under its own port count.
      phase_active    = '{32, 1, 0, 63, 0, 24};
      phase_active[4] = $urandom_range(2, 31);
      for (int ph = 0; ph < 6; ph++) begin
         sender_calm = (ph == 3);
         sink_calm   = (ph == 3);
         write_active_ports(ACTIVE_W'(phase_active[ph]));
         for (int i = 0; i < 115; i++) begin
            // Hold the results back while requests keep coming.
            if (ph == 0 && i == 20) begin
               hold_results_cycles = 250;
               sender_calm         = 1'b1;
            end
            if (ph == 0 && i == 60) sender_calm = 1'b0;
            if (ph == 1 && i == 57) wait_until_drained();
            issue_request(random_request());
         end
         wait_until_drained();
      end

      repeat (8) @(posedge clock);
      if (tracker.failures == 0) $display("PASS port_statistics_counters_top");
      else $display("FAIL port_statistics_counters_top");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("FAIL port_statistics_counters_top");
      $finish;
   end

endmodule
